// ===== hdl/cuis_pkg.sv =====
// -----------------------------------------------------------------------------
// cuis_pkg
// Constants, tables and helper functions for the user id scrambler.
// -----------------------------------------------------------------------------
package cuis_pkg;

   // Word geometry
   localparam int WORD_W  = 53;
   localparam int RES_W   = 10;
   localparam int RED_LO  = 10;
   localparam int LANES   = 6;

   // Field widths
   localparam int REGION_W = 3;
   localparam int MODEL_W  = 3;
   localparam int DEVICE_W = 32;
   localparam int GEN_W    = 16;

   // Field positions in the packed word
   localparam int REGION_POS = 50;
   localparam int MODEL_POS  = 47;
   localparam int DEVICE_POS = 15;
   localparam int GEN_POS    = 10;

   // Mixing constants
   localparam logic [RES_W:0]    POLY     = 11'h635;
   localparam logic [WORD_W-1:0] XOR_PRE  = 53'h0000B3B3B3B3B3B3;
   localparam logic [WORD_W-1:0] XOR_POST = 53'h00005E5E5E5E5E5E;
   // Sixteen-digit limit needs one bit more than the word
   localparam logic [WORD_W:0]   LIMIT_ID = 54'd9999999999999999;

   // Status codes
   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_FATAL = 1'b1;

   // Destination byte lane for each source byte lane
   localparam logic [2:0] LANE_DEST [LANES] = '{3'd1, 3'd5, 3'd0, 3'd4, 3'd2, 3'd3};

   typedef logic [WORD_W-1:0][RES_W-1:0] res_tab_type;

   // Residue of x^pos modulo POLY for every bit position of the word
   function automatic res_tab_type calc_res_tab();
      res_tab_type        tab;
      logic [WORD_W-1:0]  rem;
      logic [WORD_W-1:0]  poly_ext;
      tab      = '0;
      poly_ext = {{(WORD_W-RES_W-1){1'b0}}, POLY};
      for (int pos = 0; pos < WORD_W; pos++) begin
         rem = '0;
         rem[pos] = 1'b1;
         for (int i = 0; i <= WORD_W-1-RED_LO; i++) begin
            if (rem[WORD_W-1-i]) begin
               rem = rem ^ (poly_ext << (WORD_W-1-RED_LO-i));
            end
         end
         tab[pos] = rem[RES_W-1:0];
      end
      return tab;
   endfunction

   localparam res_tab_type RES_TAB = calc_res_tab();

   // Fixed 4-bit substitution
   function automatic logic [3:0] nib_sub(input logic [3:0] n);
      logic [3:0] s;
      case (n)
         4'h0:    s = 4'h4;
         4'h1:    s = 4'hB;
         4'h2:    s = 4'h7;
         4'h3:    s = 4'h9;
         4'h4:    s = 4'hF;
         4'h5:    s = 4'h1;
         4'h6:    s = 4'hD;
         4'h7:    s = 4'h3;
         4'h8:    s = 4'hC;
         4'h9:    s = 4'h2;
         4'hA:    s = 4'h6;
         4'hB:    s = 4'hE;
         4'hC:    s = 4'h8;
         4'hD:    s = 4'h0;
         4'hE:    s = 4'hA;
         4'hF:    s = 4'h5;
         default: s = 4'h0;
      endcase
      return s;
   endfunction

endpackage

// ===== hdl/console_user_id_scrambler_top.sv =====
// -----------------------------------------------------------------------------
// console_user_id_scrambler_top
// Packs a request, reduces it modulo a fixed polynomial and scrambles it into
// a 53-bit user id with a range status.
// -----------------------------------------------------------------------------
//
//   channel   ports                          handshake
//   --------  -----------------------------  -----------------------------
//   request   req_region_code .. req_gen...  start high, busy low
//   response  rsp_user_id, rsp_status        rsp_valid, one cycle, no stall
//
// One item per cycle; each result passes through the request register, then the
// response register around one pass of the combinational mixing logic.
// busy is always low: the pipeline never fills since the receiver cannot stall.
// Synchronous reset clears the valid flags only; payload registers are not reset.
//
module console_user_id_scrambler_top
   import cuis_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [REGION_W-1:0] req_region_code,
   input  logic [MODEL_W-1:0]  req_model_code,
   input  logic [DEVICE_W-1:0] req_device_id,
   input  logic [GEN_W-1:0]    req_generation_count,
   output logic                rsp_valid,
   output logic [WORD_W-1:0]   rsp_user_id,
   output logic                rsp_status
);

   logic                req_valid_ff;
   logic [REGION_W-1:0] region_ff;
   logic [MODEL_W-1:0]  model_ff;
   logic [DEVICE_W-1:0] device_ff;
   logic [GEN_W-1:0]    gen_ff;

   logic                rsp_valid_ff;
   logic [WORD_W-1:0]   user_id_ff;
   logic                status_ff;

   logic [WORD_W-1:0]   user_id_in;
   logic                status_in;

   logic [WORD_W-1:0]   packed_w;
   logic [RES_W-1:0]    residue;
   logic [WORD_W-1:0]   mixed_w;
   logic [WORD_W-1:0]   rot_w;
   logic [WORD_W-1:0]   sub_w;
   logic [WORD_W-1:0]   perm_w;
   logic [WORD_W-1:0]   final_w;

   assign busy = 1'b0;

   // Capture the request
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= start;
      end
      region_ff <= req_region_code;
      model_ff  <= req_model_code;
      device_ff <= req_device_id;
      gen_ff    <= req_generation_count;
   end

   // Pack the fields; device id and counter overlap and are ORed
   always_comb begin
      packed_w = (WORD_W'(region_ff) << REGION_POS)
               | (WORD_W'(model_ff)  << MODEL_POS)
               | (WORD_W'(device_ff) << DEVICE_POS)
               | (WORD_W'(gen_ff)    << GEN_POS);
   end

   // Reduce modulo the polynomial as an XOR of per-bit residues
   always_comb begin
      residue = '0;
      for (int j = RED_LO; j < WORD_W; j++) begin
         if (packed_w[j]) begin
            residue = residue ^ RES_TAB[j];
         end
      end
   end

   // Fold the residue back, whiten, rotate, substitute, permute, rotate, whiten
   always_comb begin
      mixed_w = (packed_w | WORD_W'(residue)) ^ XOR_PRE;
      rot_w   = {mixed_w[RED_LO-1:0], mixed_w[WORD_W-1:RED_LO]};

      sub_w = rot_w;
      for (int i = 0; i < LANES; i++) begin
         sub_w[8*i +: 8] = {nib_sub(rot_w[8*i+4 +: 4]), nib_sub(rot_w[8*i +: 4])};
      end

      perm_w = sub_w;
      for (int i = 0; i < LANES; i++) begin
         perm_w[8*int'(LANE_DEST[i]) +: 8] = sub_w[8*i +: 8];
      end

      final_w    = {perm_w[WORD_W-2:0], perm_w[WORD_W-1]} ^ XOR_POST;
      user_id_in = final_w;
      status_in  = ({1'b0, final_w} > LIMIT_ID) ? STATUS_FATAL : STATUS_OK;
   end

   // Hold the result for its single strobe cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= req_valid_ff;
      end
      user_id_ff <= user_id_in;
      status_ff  <= status_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_user_id = user_id_ff;
   assign rsp_status  = status_ff;

endmodule

// ===== tb/tb.sv =====
// -----------------------------------------------------------------------------
// tb
// Self-checking bench for console_user_id_scrambler_top. A directed table
// covers field extremes and overlapping device id and counter bits. A long
// random run follows, with skewed field values and random idle cycles on the
// request side. Each result is checked field by field against a typed value or
// an in-bench scrambler written at the block's widths.
// -----------------------------------------------------------------------------
module tb;
   import cuis_pkg::*;

   localparam int N_RANDOM    = 1550;
   localparam int IDLE_PCT    = 28;
   localparam int CALM_FIRST  = 500;
   localparam int CALM_LAST   = 800;
   localparam int DRAIN_AT    = 1000;
   localparam int STALL_LIMIT = 4000;
   localparam int TAIL_CYCLES = 8;
   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic [WORD_W-1:0] user_id;
      logic              status;
   } id_result_type;

   typedef struct packed {
      logic [REGION_W-1:0] region;
      logic [MODEL_W-1:0]  model;
      logic [DEVICE_W-1:0] device;
      logic [GEN_W-1:0]    gen;
      logic                known;
      id_result_type       typed;
   } id_row_type;

   // Nibble substitution and byte lane shuffle of the scrambler
   localparam logic [3:0] SBOX [16] = '{4'h4, 4'hB, 4'h7, 4'h9, 4'hF, 4'h1, 4'hD, 4'h3,
                                        4'hC, 4'h2, 4'h6, 4'hE, 4'h8, 4'h0, 4'hA, 4'h5};
   localparam int LANE_TO [LANES] = '{1, 5, 0, 4, 2, 3};

   localparam id_result_type NO_EXP = '{user_id: '0, status: STATUS_OK};

   // Directed rows; only the all-zero request carries a typed result.
   // A large identifier cannot occur: the 53-bit maximum stays under the limit.
   localparam int N_DIRECTED = 16;
   localparam id_row_type DIRECTED [N_DIRECTED] = '{
      '{3'd0, 3'd0, 32'h0000_0000, 16'h0000, 1'b1, '{53'h1B0F0E06AF0F0F, STATUS_OK}},
      '{3'd7, 3'd7, 32'hFFFF_FFFF, 16'hFFFF, 1'b0, NO_EXP},
      '{3'd7, 3'd0, 32'h0000_0000, 16'h0000, 1'b0, NO_EXP},
      '{3'd0, 3'd7, 32'h0000_0000, 16'h0000, 1'b0, NO_EXP},
      '{3'd0, 3'd0, 32'hFFFF_FFFF, 16'h0000, 1'b0, NO_EXP},
      '{3'd0, 3'd0, 32'h0000_0000, 16'hFFFF, 1'b0, NO_EXP},
      '{3'd0, 3'd0, 32'h8000_0000, 16'h0000, 1'b0, NO_EXP},
      '{3'd0, 3'd0, 32'h0000_0001, 16'h0000, 1'b0, NO_EXP},
      '{3'd0, 3'd0, 32'h0000_0000, 16'h8000, 1'b0, NO_EXP},
      '{3'd0, 3'd0, 32'h0000_0000, 16'h0001, 1'b0, NO_EXP},
      '{3'd5, 3'd2, 32'hAAAA_AAAA, 16'hAAAA, 1'b0, NO_EXP},
      '{3'd2, 3'd5, 32'h5555_5555, 16'h5555, 1'b0, NO_EXP},
      '{3'd4, 3'd1, 32'h0001_0000, 16'h0001, 1'b0, NO_EXP},
      '{3'd1, 3'd4, 32'h0000_FFFF, 16'hFFFF, 1'b0, NO_EXP},
      '{3'd3, 3'd6, 32'h1234_5678, 16'h9ABC, 1'b0, NO_EXP},
      '{3'd6, 3'd3, 32'hFFFF_0000, 16'h0000, 1'b0, NO_EXP}
   };

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic [REGION_W-1:0] req_region_code;
   logic [MODEL_W-1:0]  req_model_code;
   logic [DEVICE_W-1:0] req_device_id;
   logic [GEN_W-1:0]    req_generation_count;
   logic                rsp_valid;
   logic [WORD_W-1:0]   rsp_user_id;
   logic                rsp_status;

   id_result_type expected_ids [$];
   int            mismatch_count = 0;
   int            stall_cycles = 0;

   console_user_id_scrambler_top dut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_region_code      (req_region_code),
      .req_model_code       (req_model_code),
      .req_device_id        (req_device_id),
      .req_generation_count (req_generation_count),
      .rsp_valid            (rsp_valid),
      .rsp_user_id          (rsp_user_id),
      .rsp_status           (rsp_status)
   );

   always #6 clock = ~clock;

   // Pack, reduce, whiten, rotate, substitute, shuffle, rotate, whiten
   function automatic id_result_type scramble_id(input logic [REGION_W-1:0] region,
                                                 input logic [MODEL_W-1:0]  model,
                                                 input logic [DEVICE_W-1:0] device,
                                                 input logic [GEN_W-1:0]    gen);
      logic [WORD_W-1:0] word;
      logic [WORD_W-1:0] rem;
      logic [WORD_W-1:0] w;
      logic [WORD_W-1:0] src;
      logic [7:0]        b;
      id_result_type     res;
      word = (WORD_W'(region) << REGION_POS) | (WORD_W'(model) << MODEL_POS)
           | (WORD_W'(device) << DEVICE_POS) | (WORD_W'(gen) << GEN_POS);
      rem = word;
      for (int i = WORD_W - 1; i >= RED_LO; i--) begin
         if (rem[i]) begin
            rem = rem ^ (WORD_W'(POLY) << (i - RED_LO));
         end
      end
      w = (word | WORD_W'(rem[31:0])) ^ XOR_PRE;
      w = {w[9:0], w[WORD_W-1:10]};
      for (int i = 0; i < LANES; i++) begin
         b = w[i*8 +: 8];
         w[i*8 +: 8] = {SBOX[b[7:4]], SBOX[b[3:0]]};
      end
      src = w;
      for (int i = 0; i < LANES; i++) begin
         w[LANE_TO[i]*8 +: 8] = src[i*8 +: 8];
      end
      w = {w[WORD_W-2:0], w[WORD_W-1]};
      w = w ^ XOR_POST;
      res.user_id = w;
      res.status  = ({1'b0, w} > LIMIT_ID) ? STATUS_FATAL : STATUS_OK;
      return res;
   endfunction

   // Mostly uniform, with all-zero and all-one values mixed in
   function automatic logic [31:0] skewed_value();
      case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         default: return $urandom;
      endcase
   endfunction

   task automatic flag_error(input string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
         $display("%0t: %s", $realtime, msg);
      end
   endtask

   // Idle at random, present the item, hold it until taken, then queue its result
   task automatic issue_request(input logic [REGION_W-1:0] region,
                                input logic [MODEL_W-1:0]  model,
                                input logic [DEVICE_W-1:0] device,
                                input logic [GEN_W-1:0]    gen,
                                input logic                known,
                                input id_result_type       typed,
                                input bit                  allow_idle);
      while (allow_idle && $urandom_range(99) < IDLE_PCT) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start                <= 1'b1;
      req_region_code      <= region;
      req_model_code       <= model;
      req_device_id        <= device;
      req_generation_count <= gen;
      do @(posedge clock); while (busy);
      expected_ids.push_back(known ? typed : scramble_id(region, model, device, gen));
   endtask

   // Check each result against the oldest expectation
   always @(posedge clock) begin
      id_result_type exp;
      if (!reset && rsp_valid) begin
         if (expected_ids.size() == 0) begin
            flag_error($sformatf("unexpected result user_id=%h status=%b",
                                 rsp_user_id, rsp_status));
         end else begin
            exp = expected_ids.pop_front();
            if (rsp_user_id !== exp.user_id || rsp_status !== exp.status) begin
               flag_error($sformatf("user_id exp %h got %h, status exp %b got %b",
                                    exp.user_id, rsp_user_id, exp.status, rsp_status));
            end
         end
      end
   end

   // End the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   initial begin
      clock                = 1'b0;
      reset                = 1'b1;
      start                = 1'b0;
      req_region_code      = '0;
      req_model_code       = '0;
      req_device_id        = '0;
      req_generation_count = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed table
      for (int i = 0; i < N_DIRECTED; i++) begin
         issue_request(DIRECTED[i].region, DIRECTED[i].model, DIRECTED[i].device,
                       DIRECTED[i].gen, DIRECTED[i].known, DIRECTED[i].typed, 1'b1);
      end

      // Random items, with a calm stretch and one full drain on the way
      for (int i = 0; i < N_RANDOM; i++) begin
         if (i == DRAIN_AT) begin
            while (expected_ids.size() != 0) begin
               start <= 1'b0;
               @(posedge clock);
            end
         end
         issue_request(REGION_W'(skewed_value()), MODEL_W'(skewed_value()),
                       skewed_value(), GEN_W'(skewed_value()), 1'b0, NO_EXP,
                       !(i >= CALM_FIRST && i < CALM_LAST));
      end
      start <= 1'b0;

      // Drain, then let the pipeline settle
      while (expected_ids.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
